/* src/mconv_pkg.sv */
// Shared types, constants and helpers of the multichannel convolution unit.
package mconv_pkg;

   // Fixed field widths of the request and result words
   localparam int DATA_BITS     = 16;
   localparam int SUM_BITS      = 40;
   localparam int PROD_BITS     = 2 * DATA_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 5;

   // Default sizes of the channel, kernel and image stores
   localparam int MAX_IN_CH_DEF  = 4;
   localparam int MAX_OUT_CH_DEF = 4;
   localparam int MAX_KERNEL_DEF = 3;
   localparam int MAX_IMAGE_DEF  = 16;

   // Widths that cover every parameter value in range
   localparam int CH_CNT_BITS  = 5;   // channel counts up to 16
   localparam int CH_IDX_BITS  = 4;   // channel index up to 15
   localparam int K_CNT_BITS   = 3;   // kernel size up to 7
   localparam int IMG_CNT_BITS = 9;   // image size up to 256
   localparam int POS_BITS     = 8;   // image position up to 255

   // Operation codes
   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_PIXEL  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_CHANNELS  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_CHANNELS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_ROWS  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_COLS  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_ROWS   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_COLS   = 3'd5;

   typedef struct packed {
      logic                        operation;
      logic [1:0]                  weight_out_channel;
      logic [1:0]                  weight_in_channel;
      logic [1:0]                  weight_row;
      logic [1:0]                  weight_col;
      logic signed [DATA_BITS-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                 out_channel;
      logic [3:0]                 out_row;
      logic [3:0]                 out_col;
      logic signed [SUM_BITS-1:0] sum;
      logic                       last;
   } rsp_word_type;

   // Clamped geometry seen by the controller
   typedef struct packed {
      logic [CH_CNT_BITS-1:0]  in_ch;
      logic [CH_CNT_BITS-1:0]  out_ch;
      logic [K_CNT_BITS-1:0]   kern_r;
      logic [K_CNT_BITS-1:0]   kern_c;
      logic [IMG_CNT_BITS-1:0] img_r;
      logic [IMG_CNT_BITS-1:0] img_c;
   } mconv_cfg_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic                   weight_we;
      logic                   tap_go;
      logic                   fresh;
      logic [CH_IDX_BITS-1:0] chan;
      logic [K_CNT_BITS-1:0]  tap_m;
      logic [K_CNT_BITS-1:0]  tap_n;
      logic [POS_BITS-1:0]    pos_r;
      logic [POS_BITS-1:0]    pos_c;
      logic                   res_read;
      logic                   res_load;
      logic [CH_IDX_BITS-1:0] res_o;
      logic                   res_last;
   } mconv_cmd_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int clamp_count(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

endpackage

/* src/mconv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mconv_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 16,
   parameter int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);
   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/mconv_ctrl.sv */
// Controller: pixel position counters, tap sequencing and result emission.
module mconv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  mconv_pkg::req_word_type req_word,
   output logic                    req_stall,
   input  mconv_pkg::mconv_cfg_type cfg,
   input  logic                    out_free,
   output mconv_pkg::mconv_cmd_type cmd
);
   import mconv_pkg::*;

   localparam int WB = IMG_CNT_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TAP, ST_DRAIN1, ST_DRAIN2, ST_READ, ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CH_IDX_BITS-1:0]  chan_ff, chan_in;
   logic [POS_BITS-1:0]     row_ff, row_in;
   logic [POS_BITS-1:0]     col_ff, col_in;
   logic [CH_IDX_BITS-1:0]  pix_c_ff, pix_c_in;
   logic [POS_BITS-1:0]     pix_r_ff, pix_r_in;
   logic [POS_BITS-1:0]     pix_q_ff, pix_q_in;
   logic [K_CNT_BITS-1:0]   tap_m_ff, tap_m_in;
   logic [K_CNT_BITS-1:0]   tap_n_ff, tap_n_in;
   logic [CH_IDX_BITS-1:0]  res_o_ff, res_o_in;

   logic          accept;
   logic          grid_ok;
   logic [WB-1:0] orows, ocols;
   logic [WB-1:0] r_w, q_w, m_w, n_w, tr, tc, wr, wc;
   logic          tap_ok, win_ok, tap_end, emit_end;

   // Output grid size
   always_comb begin
      grid_ok = (cfg.img_r >= IMG_CNT_BITS'(cfg.kern_r))
             && (cfg.img_c >= IMG_CNT_BITS'(cfg.kern_c));
      orows   = WB'(cfg.img_r) - WB'(cfg.kern_r) + WB'(1);
      ocols   = WB'(cfg.img_c) - WB'(cfg.kern_c) + WB'(1);
   end

   // Tap target and window checks for the pixel in flight
   always_comb begin
      r_w    = WB'(pix_r_ff);
      q_w    = WB'(pix_q_ff);
      m_w    = WB'(tap_m_ff);
      n_w    = WB'(tap_n_ff);
      tr     = r_w - m_w;
      tc     = q_w - n_w;
      tap_ok = (r_w >= m_w) && (q_w >= n_w) && (tr < orows) && (tc < ocols);
      wr     = r_w + WB'(1) - WB'(cfg.kern_r);
      wc     = q_w + WB'(1) - WB'(cfg.kern_c);
      win_ok = (CH_CNT_BITS'(pix_c_ff) + CH_CNT_BITS'(1) == cfg.in_ch)
            && (r_w + WB'(1) >= WB'(cfg.kern_r))
            && (q_w + WB'(1) >= WB'(cfg.kern_c))
            && (wr < orows) && (wc < ocols);
      tap_end  = (K_CNT_BITS'(tap_n_ff + 1'b1) == cfg.kern_c)
              && (K_CNT_BITS'(tap_m_ff + 1'b1) == cfg.kern_r);
      emit_end = (CH_CNT_BITS'(res_o_ff) + CH_CNT_BITS'(1) == cfg.out_ch);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Commands
   always_comb begin
      cmd           = '0;
      cmd.weight_we = accept && (req_word.operation == OP_WEIGHT);
      cmd.chan      = pix_c_ff;
      cmd.tap_m     = tap_m_ff;
      cmd.tap_n     = tap_n_ff;
      cmd.res_o     = res_o_ff;
      cmd.res_last  = emit_end;
      if (state_ff == ST_TAP) begin
         cmd.tap_go = tap_ok;
         cmd.fresh  = (pix_c_ff == '0) && (tap_m_ff == '0) && (tap_n_ff == '0);
         cmd.pos_r  = POS_BITS'(tr);
         cmd.pos_c  = POS_BITS'(tc);
      end else begin
         cmd.pos_r  = POS_BITS'(wr);
         cmd.pos_c  = POS_BITS'(wc);
      end
      cmd.res_read = (state_ff == ST_READ);
      cmd.res_load = (state_ff == ST_EMIT) && out_free;
   end

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      pix_c_in = pix_c_ff;
      pix_r_in = pix_r_ff;
      pix_q_in = pix_q_ff;
      tap_m_in = tap_m_ff;
      tap_n_in = tap_n_ff;
      res_o_in = res_o_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.operation == OP_PIXEL)) begin
               pix_c_in = chan_ff;
               pix_r_in = row_ff;
               pix_q_in = col_ff;
               tap_m_in = '0;
               tap_n_in = '0;
               res_o_in = '0;
               if (grid_ok) begin
                  state_in = ST_TAP;
               end
               // advance the pixel position, wrap at the bounds
               if (IMG_CNT_BITS'(col_ff) + IMG_CNT_BITS'(1) >= cfg.img_c) begin
                  col_in = '0;
                  if (IMG_CNT_BITS'(row_ff) + IMG_CNT_BITS'(1) >= cfg.img_r) begin
                     row_in = '0;
                     if (CH_CNT_BITS'(chan_ff) + CH_CNT_BITS'(1) >= cfg.in_ch) begin
                        chan_in = '0;
                     end else begin
                        chan_in = chan_ff + 1'b1;
                     end
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_TAP: begin
            if (tap_end) begin
               state_in = ST_DRAIN1;
            end else if (K_CNT_BITS'(tap_n_ff + 1'b1) == cfg.kern_c) begin
               tap_n_in = '0;
               tap_m_in = tap_m_ff + 1'b1;
            end else begin
               tap_n_in = tap_n_ff + 1'b1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = win_ok ? ST_READ : ST_IDLE;
         ST_READ:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (emit_end) begin
                  state_in = ST_IDLE;
               end else begin
                  res_o_in = res_o_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
      pix_c_ff <= pix_c_in;
      pix_r_ff <= pix_r_in;
      pix_q_ff <= pix_q_in;
      tap_m_ff <= tap_m_in;
      tap_n_ff <= tap_n_in;
      res_o_ff <= res_o_in;
   end
endmodule

/* src/mconv_dpath.sv */
// Datapath: weight and partial sum memories, multiply-accumulate, result register.
module mconv_dpath #(
   parameter int MAX_IN_CH  = mconv_pkg::MAX_IN_CH_DEF,
   parameter int MAX_OUT_CH = mconv_pkg::MAX_OUT_CH_DEF,
   parameter int MAX_KERNEL = mconv_pkg::MAX_KERNEL_DEF,
   parameter int MAX_IMAGE  = mconv_pkg::MAX_IMAGE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mconv_pkg::req_word_type  req_word,
   input  logic                     req_accept,
   input  mconv_pkg::mconv_cmd_type cmd,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mconv_pkg::rsp_word_type  rsp_word
);
   import mconv_pkg::*;

   localparam int W_DEPTH = MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
   localparam int P_DEPTH = MAX_IMAGE * MAX_IMAGE;
   localparam int WAB     = addr_bits(W_DEPTH);
   localparam int PAB     = addr_bits(P_DEPTH);

   logic signed [DATA_BITS-1:0] pixel_ff;
   logic                        s1_valid_ff, s1_fresh_ff;
   logic [PAB-1:0]              s1_addr_ff;
   logic                        s2_valid_ff, s2_fresh_ff;
   logic [PAB-1:0]              s2_addr_ff;

   logic [WAB-1:0] w_wr_addr, w_rd_addr;
   logic [PAB-1:0] p_rd_addr;
   logic           w_addr_ok;

   logic [DATA_BITS-1:0]        w_rdata  [MAX_OUT_CH];
   logic [SUM_BITS-1:0]         p_rdata  [MAX_OUT_CH];
   logic signed [PROD_BITS-1:0] prod_ff  [MAX_OUT_CH];
   logic [SUM_BITS-1:0]         old_ff   [MAX_OUT_CH];
   logic [SUM_BITS-1:0]         new_sum  [MAX_OUT_CH];

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff;
   logic [SUM_BITS-1:0]  res_sum;

   // Address generation
   always_comb begin
      w_addr_ok = (int'(req_word.weight_out_channel) < MAX_OUT_CH)
               && (int'(req_word.weight_in_channel) < MAX_IN_CH)
               && (int'(req_word.weight_row) < MAX_KERNEL)
               && (int'(req_word.weight_col) < MAX_KERNEL);
      w_wr_addr = WAB'((int'(req_word.weight_in_channel) * MAX_KERNEL
                 + int'(req_word.weight_row)) * MAX_KERNEL + int'(req_word.weight_col));
      w_rd_addr = WAB'((int'(cmd.chan) * MAX_KERNEL + int'(cmd.tap_m)) * MAX_KERNEL
                 + int'(cmd.tap_n));
      p_rd_addr = PAB'(int'(cmd.pos_r) * MAX_IMAGE + int'(cmd.pos_c));
   end

   // Per output channel memories and MAC
   for (genvar k = 0; k < MAX_OUT_CH; k++) begin : g_lane
      mconv_ram #(.DATA_WIDTH(DATA_BITS), .DEPTH(W_DEPTH), .ADDR_BITS(WAB)) u_wram (
         .clock   (clock),
         .wr_en   (cmd.weight_we && w_addr_ok
                   && (int'(req_word.weight_out_channel) == k)),
         .wr_addr (w_wr_addr),
         .wr_data (req_word.value),
         .rd_en   (cmd.tap_go),
         .rd_addr (w_rd_addr),
         .rd_data (w_rdata[k])
      );

      mconv_ram #(.DATA_WIDTH(SUM_BITS), .DEPTH(P_DEPTH), .ADDR_BITS(PAB)) u_pram (
         .clock   (clock),
         .wr_en   (s2_valid_ff),
         .wr_addr (s2_addr_ff),
         .wr_data (new_sum[k]),
         .rd_en   (cmd.tap_go || cmd.res_read),
         .rd_addr (p_rd_addr),
         .rd_data (p_rdata[k])
      );

      // multiply weight by pixel, keep the old partial sum
      always_ff @(posedge clock) begin
         prod_ff[k] <= $signed(w_rdata[k]) * pixel_ff;
         old_ff[k]  <= p_rdata[k];
      end

      // add into the partial sum, or start it fresh
      always_comb begin
         if (s2_fresh_ff) begin
            new_sum[k] = SUM_BITS'(prod_ff[k]);
         end else begin
            new_sum[k] = old_ff[k] + SUM_BITS'(prod_ff[k]);
         end
      end
   end

   // Latch the pixel and advance the MAC pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.tap_go;
         s2_valid_ff <= s1_valid_ff;
      end
      if (req_accept && (req_word.operation == OP_PIXEL)) begin
         pixel_ff <= req_word.value;
      end
      s1_fresh_ff <= cmd.fresh;
      s1_addr_ff  <= p_rd_addr;
      s2_fresh_ff <= s1_fresh_ff;
      s2_addr_ff  <= s1_addr_ff;
   end

   // Select the result sum of the current output channel
   always_comb begin
      res_sum = p_rdata[0];
      for (int k = 0; k < MAX_OUT_CH; k++) begin
         if (int'(cmd.res_o) == k) begin
            res_sum = p_rdata[k];
         end
      end
   end

   // Output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.res_load) begin
         rsp_word_ff.out_channel <= cmd.res_o[1:0];
         rsp_word_ff.out_row     <= cmd.pos_r[3:0];
         rsp_word_ff.out_col     <= cmd.pos_c[3:0];
         rsp_word_ff.sum         <= res_sum;
         rsp_word_ff.last        <= cmd.res_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule

/* src/multichannel_conv2d_valid_unit.sv */
// Top level of the multichannel valid-mode 2D convolution unit.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | req_word (weight write or pixel)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_word (one output channel sum)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// A weight write is written into the weight memory in its accept cycle. A pixel
// takes its accept cycle, then steps through kernel_rows*kernel_cols taps, all output
// channels in parallel, then the partial sum read-modify-write pipeline drains.
// A pixel that closes a window adds a read state and one emit per output channel,
// each held while rsp_stall. Reset clears the pixel counters and the configuration
// registers; the memories are not cleared.
module multichannel_conv2d_valid_unit #(
   parameter int MAX_IN_CH  = mconv_pkg::MAX_IN_CH_DEF,
   parameter int MAX_OUT_CH = mconv_pkg::MAX_OUT_CH_DEF,
   parameter int MAX_KERNEL = mconv_pkg::MAX_KERNEL_DEF,
   parameter int MAX_IMAGE  = mconv_pkg::MAX_IMAGE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mconv_pkg::req_word_type            req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mconv_pkg::rsp_word_type            rsp_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mconv_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mconv_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import mconv_pkg::*;

   logic [2:0] in_ch_ff, in_ch_in;
   logic [2:0] out_ch_ff, out_ch_in;
   logic [1:0] kern_r_ff, kern_r_in;
   logic [1:0] kern_c_ff, kern_c_in;
   logic [4:0] img_r_ff, img_r_in;
   logic [4:0] img_c_ff, img_c_in;

   mconv_cfg_type cfg;
   mconv_cmd_type cmd;
   logic          out_free;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register writes; saturate oversize values into the register width
   always_comb begin
      in_ch_in  = in_ch_ff;
      out_ch_in = out_ch_ff;
      kern_r_in = kern_r_ff;
      kern_c_in = kern_c_ff;
      img_r_in  = img_r_ff;
      img_c_in  = img_c_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IN_CHANNELS:  in_ch_in  = (csr_data > 5'd7) ? 3'd7 : csr_data[2:0];
            CSR_OUT_CHANNELS: out_ch_in = (csr_data > 5'd7) ? 3'd7 : csr_data[2:0];
            CSR_KERNEL_ROWS:  kern_r_in = (csr_data > 5'd3) ? 2'd3 : csr_data[1:0];
            CSR_KERNEL_COLS:  kern_c_in = (csr_data > 5'd3) ? 2'd3 : csr_data[1:0];
            CSR_IMAGE_ROWS:   img_r_in  = csr_data;
            CSR_IMAGE_COLS:   img_c_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= 3'd1;
         out_ch_ff <= 3'd1;
         kern_r_ff <= 2'd3;
         kern_c_ff <= 2'd3;
         img_r_ff  <= 5'd9;
         img_c_ff  <= 5'd9;
      end else begin
         in_ch_ff  <= in_ch_in;
         out_ch_ff <= out_ch_in;
         kern_r_ff <= kern_r_in;
         kern_c_ff <= kern_c_in;
         img_r_ff  <= img_r_in;
         img_c_ff  <= img_c_in;
      end
   end

   // Saturate the registers into their usable ranges
   always_comb begin
      cfg.in_ch  = CH_CNT_BITS'(clamp_count(int'(in_ch_ff), MAX_IN_CH));
      cfg.out_ch = CH_CNT_BITS'(clamp_count(int'(out_ch_ff), MAX_OUT_CH));
      cfg.kern_r = K_CNT_BITS'(clamp_count(int'(kern_r_ff), MAX_KERNEL));
      cfg.kern_c = K_CNT_BITS'(clamp_count(int'(kern_c_ff), MAX_KERNEL));
      cfg.img_r  = IMG_CNT_BITS'(clamp_count(int'(img_r_ff), MAX_IMAGE));
      cfg.img_c  = IMG_CNT_BITS'(clamp_count(int'(img_c_ff), MAX_IMAGE));
   end

   mconv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .cfg       (cfg),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   mconv_dpath #(
      .MAX_IN_CH  (MAX_IN_CH),
      .MAX_OUT_CH (MAX_OUT_CH),
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_IMAGE  (MAX_IMAGE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .req_accept (req_valid && !req_stall),
      .cmd        (cmd),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   // A loaded result shows up on the result channel
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   // No word is taken while taps are in flight
   a_no_accept_in_taps: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_go |-> req_stall)
      else $error("input accepted during tap sequence");

   // A pixel with fewer image rows than kernel rows leaves the unit idle
   a_small_image_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_word.operation == OP_PIXEL)
       && (cfg.img_r < IMG_CNT_BITS'(cfg.kern_r))) |=> !req_stall)
      else $error("unit busy on a pixel without an output grid");

   // A write beyond the register list changes nothing
   a_bad_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index != CSR_IN_CHANNELS) && (csr_index != CSR_OUT_CHANNELS)
       && (csr_index != CSR_KERNEL_ROWS) && (csr_index != CSR_KERNEL_COLS)
       && (csr_index != CSR_IMAGE_ROWS) && (csr_index != CSR_IMAGE_COLS))
      |=> $stable(cfg))
      else $error("out-of-range register index changed the configuration");
endmodule

/* tb/tb.sv */
// Self-checking testbench for the multichannel valid-mode convolution unit.
`timescale 1ns / 1ps

module tb;
   import mconv_pkg::*;

   // Register indexes past the end of the register file
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   multichannel_conv2d_valid_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state: weights, partial sums, pixel position and raw registers
   logic signed [15:0] kernel_wt [4][4][3][3];
   logic [39:0] window_sum [4][16][16];
   int unsigned pos_ch, pos_row, pos_col;
   logic [4:0] reg_raw [6];
   rsp_word_type sums_due [$];

   int error_count = 0;
   int pixels_sent = 0;
   int weights_sent = 0;
   int words_checked = 0;
   int random_pixels = 0;
   bit steady = 1'b0;       // no idling on either side
   int hold_off = 0;        // long receiver hold, counted down by its own process

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // Count down the long receiver hold
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) hold_off--;
      end
   end

   function automatic int unsigned sat_count(logic [4:0] raw, int unsigned hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // Accumulate one pixel into the partial sums and queue any finished windows
   task automatic conv_predict_pixel(logic signed [15:0] px);
      int unsigned ic, oc, kr, kc, ir, icl, orows, ocols, pr, pc;
      longint prod;
      rsp_word_type e;
      ic  = sat_count(reg_raw[0], 4);
      oc  = sat_count(reg_raw[1], 4);
      kr  = sat_count(reg_raw[2], 3);
      kc  = sat_count(reg_raw[3], 3);
      ir  = sat_count(reg_raw[4], 16);
      icl = sat_count(reg_raw[5], 16);
      if (pos_ch < 4 && ir >= kr && icl >= kc) begin
         orows = ir - kr + 1;
         ocols = icl - kc + 1;
         for (int o = 0; o < oc; o++)
            for (int m = 0; m < kr; m++)
               for (int n = 0; n < kc; n++) begin
                  if (pos_row < m || pos_col < n) continue;
                  pr = pos_row - m;
                  pc = pos_col - n;
                  if (pr >= orows || pc >= ocols) continue;
                  prod = longint'(kernel_wt[o][pos_ch][m][n]) * longint'(px);
                  if (pos_ch == 0 && m == 0 && n == 0)
                     window_sum[o][pr][pc] = prod[39:0];
                  else
                     window_sum[o][pr][pc] = window_sum[o][pr][pc] + prod[39:0];
               end
         if (pos_ch == ic - 1 && pos_row + 1 >= kr && pos_col + 1 >= kc) begin
            pr = pos_row + 1 - kr;
            pc = pos_col + 1 - kc;
            if (pr < orows && pc < ocols)
               for (int o = 0; o < oc; o++) begin
                  e.out_channel = o[1:0];
                  e.out_row     = pr[3:0];
                  e.out_col     = pc[3:0];
                  e.sum         = window_sum[o][pr][pc];
                  e.last        = (o + 1 == oc);
                  sums_due.push_back(e);
               end
         end
      end
      // advance the pixel position
      if (pos_col + 1 >= icl) begin
         pos_col = 0;
         if (pos_row + 1 >= ir) begin
            pos_row = 0;
            pos_ch = (pos_ch + 1 >= ic) ? 0 : pos_ch + 1;
         end else
            pos_row = pos_row + 1;
      end else
         pos_col = pos_col + 1;
   endtask

   // Offer one word, hold it until taken, then update the predictor
   task automatic send_word(req_word_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      if (w.operation == OP_WEIGHT) begin
         weights_sent++;
         if (w.weight_row < 3 && w.weight_col < 3)
            kernel_wt[w.weight_out_channel][w.weight_in_channel][w.weight_row]
               [w.weight_col] = w.value;
      end else begin
         pixels_sent++;
         conv_predict_pixel(w.value);
      end
   endtask

   task automatic send_weight(int o, int i, int r, int c, logic signed [15:0] v);
      req_word_type w;
      w = '0;
      w.operation = OP_WEIGHT;
      w.weight_out_channel = o[1:0];
      w.weight_in_channel  = i[1:0];
      w.weight_row = r[1:0];
      w.weight_col = c[1:0];
      w.value = v;
      send_word(w);
   endtask

   task automatic send_pixel(logic signed [15:0] v);
      req_word_type w;
      w = '0;
      w.operation = OP_PIXEL;
      w.weight_out_channel = 2'($urandom_range(0, 3));
      w.weight_in_channel  = 2'($urandom_range(0, 3));
      w.weight_row = 2'($urandom_range(0, 3));
      w.weight_col = 2'($urandom_range(0, 3));
      w.value = v;
      send_word(w);
   endtask

   // Stop offering and wait until every expected word is out and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [4:0] data);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < 6) reg_raw[idx] = data;
      @(posedge clock);
   endtask

   task automatic set_geometry(int ic, int oc, int kr, int kc, int ir, int icl);
      write_reg(CSR_IN_CHANNELS,  ic[4:0]);
      write_reg(CSR_OUT_CHANNELS, oc[4:0]);
      write_reg(CSR_KERNEL_ROWS,  kr[4:0]);
      write_reg(CSR_KERNEL_COLS,  kc[4:0]);
      write_reg(CSR_IMAGE_ROWS,   ir[4:0]);
      write_reg(CSR_IMAGE_COLS,   icl[4:0]);
   endtask

   // Send pixels until the position wraps back to the start of a frame;
   // mode 0 random, 1 most negative, 2 most positive; mix_weights mixes in weight writes
   task automatic run_frame(int mode, bit mix_weights);
      logic signed [15:0] v;
      do begin
         if (mix_weights && $urandom_range(0, 7) == 0)
            send_weight($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 2),
                        $urandom_range(0, 2), 16'($urandom_range(0, 65535)));
         v = (mode == 1) ? 16'sh8000 : (mode == 2) ? 16'sh7fff
                                                   : 16'($urandom_range(0, 65535));
         send_pixel(v);
      end while (pos_ch != 0 || pos_row != 0 || pos_col != 0);
   endtask

   // Result side: check each accepted word, then draw the next stall
   initial begin
      int pause;
      rsp_word_type e;
      pause = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            words_checked++;
            if (sums_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result word %p", rsp_word);
            end else begin
               e = sums_due.pop_front();
               if (rsp_word.out_channel !== e.out_channel || rsp_word.out_row !== e.out_row ||
                   rsp_word.out_col !== e.out_col || rsp_word.sum !== e.sum ||
                   rsp_word.last !== e.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected ch %0d row %0d col %0d sum %0d last %0b,",
                              e.out_channel, e.out_row, e.out_col, e.sum, e.last,
                              " got ch %0d row %0d col %0d sum %0d last %0b",
                              rsp_word.out_channel, rsp_word.out_row, rsp_word.out_col,
                              rsp_word.sum, rsp_word.last);
               end
            end
            pause = steady ? 0 : $urandom_range(0, 7);
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
         end else if (pause > 0) begin
            pause--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // Write every weight so no tap ever reads an empty entry; address
   // rows and columns past the kernel, which must be dropped
   task automatic test_weight_load();
      for (int o = 0; o < 4; o++)
         for (int i = 0; i < 4; i++)
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 3; c++)
                  send_weight(o, i, r, c, 16'sh8000);
      send_weight(3, 3, 3, 0, 16'sh1234);
      send_weight(0, 1, 1, 3, 16'sh7fff);
      send_weight(2, 0, 3, 3, 16'sh0001);
   endtask

   // Full-scale pixels against full-scale weights, four output channels
   task automatic test_extreme_values();
      set_geometry(1, 4, 3, 3, 3, 3);
      run_frame(1, 1'b0);
      run_frame(2, 1'b0);
      drain();
   endtask

   // Zero and oversize register values saturate; spare indexes are ignored
   task automatic test_register_saturation();
      for (int k = 0; k < 6; k++) write_reg(k[CSR_IDX_BITS-1:0], 5'd0);
      write_reg(CSR_SPARE_LO, 5'd31);
      write_reg(CSR_SPARE_HI, 5'd2);
      run_frame(0, 1'b0);
      drain();
      for (int k = 0; k < 4; k++) write_reg(k[CSR_IDX_BITS-1:0], 5'd31);
      write_reg(CSR_IMAGE_ROWS, 5'd4);
      write_reg(CSR_IMAGE_COLS, 5'd4);
      run_frame(0, 1'b0);
      drain();
   endtask

   // Image smaller than the kernel yields no results at all
   task automatic test_small_image();
      set_geometry(1, 2, 3, 3, 2, 5);
      run_frame(0, 1'b0);
      drain();
   endtask

   // Hold the result side off while pixels keep coming, so the block backs up
   task automatic test_back_pressure();
      set_geometry(1, 4, 1, 1, 4, 4);
      hold_off = 300;
      run_frame(0, 1'b0);
      drain();
   endtask

   // Shrink the output channel count partway through a frame
   task automatic test_mid_frame_change();
      set_geometry(2, 4, 2, 2, 4, 4);
      for (int k = 0; k < 10; k++) send_pixel(16'($urandom_range(0, 65535)));
      drain();
      write_reg(CSR_OUT_CHANNELS, 5'd1);
      run_frame(0, 1'b0);
      drain();
   endtask

   // Random geometries, mostly small, with weight rewrites mixed in
   task automatic test_random_frames();
      int ir, icl, ic, before_px;
      while (random_pixels < 50) begin
         steady = ($urandom_range(0, 4) == 0);
         ic = $urandom_range(1, 4);
         ir = $urandom_range(1, 6);
         icl = $urandom_range(1, 6);
         if ($urandom_range(0, 11) == 0) begin
            ir = 16;
            icl = $urandom_range(0, 1) ? 16 : 3;
            ic = 1;
         end
         set_geometry(ic, $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
                      ir, icl);
         before_px = pixels_sent;
         run_frame(0, 1'b1);
         if ($urandom_range(0, 1)) run_frame(0, 1'b1);
         random_pixels += pixels_sent - before_px;
         drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < 6; k++) reg_raw[k] = 5'd0;
      reg_raw[0] = 5'd1;
      reg_raw[1] = 5'd1;
      reg_raw[2] = 5'd3;
      reg_raw[3] = 5'd3;
      reg_raw[4] = 5'd9;
      reg_raw[5] = 5'd9;
      pos_ch = 0;
      pos_row = 0;
      pos_col = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_weight_load();
      test_extreme_values();
      test_register_saturation();
      test_small_image();
      test_back_pressure();
      test_mid_frame_change();
      test_random_frames();
      drain();

      $display("covered %0d pixels and %0d weight writes over many geometries,",
               pixels_sent, weights_sent);
      $display("%0d result words checked, %0d errors", words_checked, error_count);
      if (error_count == 0 && sums_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
src/mconv_pkg.sv
src/mconv_ram.sv
src/mconv_ctrl.sv
src/mconv_dpath.sv
src/multichannel_conv2d_valid_unit.sv
tb/tb.sv
